>>> hdl/gbba_pkg.sv
// ----------------------------------------------------------------------------
// gbba_pkg
// Shared types and constants of the grouped bitmap block allocator: field
// widths, config register indexes, result codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gbba_pkg;

	// default sizing of the map
	localparam int MAX_GROUPS_DEF     = 16;
	localparam int BITS_PER_GROUP_DEF = 8192;

	// field widths
	localparam int BLK_W  = 18;
	localparam int HINT_W = 4;
	localparam int CODE_W = 3;
	localparam int GIN_W  = 5;
	localparam int BPG_W  = 14;
	localparam int CNT_W  = 14;
	localparam int CFG_W  = 18;
	localparam int IDX_W  = 2;

	// config register indexes
	localparam logic [IDX_W-1:0] CFG_GROUPS     = 2'd0;
	localparam logic [IDX_W-1:0] CFG_BPG        = 2'd1;
	localparam logic [IDX_W-1:0] CFG_TOTAL      = 2'd2;
	localparam logic [IDX_W-1:0] CFG_FIRST_DATA = 2'd3;

	// config reset values
	localparam logic [GIN_W-1:0] GIN_RST   = 5'd16;
	localparam logic [BPG_W-1:0] BPG_RST   = 14'd8192;
	localparam logic [BLK_W-1:0] TOTAL_RST = 18'd131072;

	// result codes
	localparam logic [CODE_W-1:0] RC_ALLOC   = 3'd0;
	localparam logic [CODE_W-1:0] RC_FREED   = 3'd1;
	localparam logic [CODE_W-1:0] RC_NOSPACE = 3'd2;
	localparam logic [CODE_W-1:0] RC_RANGE   = 3'd3;
	localparam logic [CODE_W-1:0] RC_DOUBLE  = 3'd4;

	// item kinds
	localparam logic KIND_ALLOC = 1'b0;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_DECIDE,
		S_GRP,
		S_GTEST,
		S_SCAN,
		S_AWR,
		S_FRD,
		S_FWAIT,
		S_RES
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              clr_step;
		logic              take;
		logic              div_go;
		logic              alloc_init;
		logic              free_init;
		logic              grp_init;
		logic              next_grp;
		logic              scan;
		logic              alloc_wr;
		logic              free_wr;
		logic              set_code;
		logic [CODE_W-1:0] code;
		logic              res_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic kind;
		logic div_busy;
		logic no_room;
		logic free_bad;
		logic full;
		logic last_try;
		logic hit;
		logic gdone;
		logic bit_clear;
		logic out_busy;
	} stat_t;

endpackage

>>> hdl/gbba_div.sv
// ----------------------------------------------------------------------------
// gbba_div
// Restoring divider, one quotient bit per cycle. Quotient and remainder
// stay valid after busy falls until the next start.
// ----------------------------------------------------------------------------
module gbba_div #(
	parameter int DW = 18,
	parameter int VW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quo,
	output logic [VW-1:0] rmd
);
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rmd_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   trial;

	// shift in the next dividend bit
	assign trial = {rmd_q, quo_q[DW-1]};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rmd_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rmd_q <= VW'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rmd_q <= VW'(trial);
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rmd  = rmd_q;

endmodule

>>> hdl/gbba_ctrl.sv
// ----------------------------------------------------------------------------
// gbba_ctrl
// Sequencer of the allocator: clearing pass, item intake, division, group
// walk, word scan, map update and result hand-off.
// ----------------------------------------------------------------------------
module gbba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  gbba_pkg::stat_t stat,
	output gbba_pkg::cmd_t  cmd
);
	import gbba_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = S_DIV_GO;
				end
			end
			S_DIV_GO: begin
				cmd.div_go = 1'b1;
				state_d    = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (!stat.div_busy) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.kind != KIND_ALLOC) begin
					if (stat.free_bad) begin
						cmd.set_code = 1'b1;
						cmd.code     = RC_RANGE;
						state_d      = S_RES;
					end else begin
						cmd.free_init = 1'b1;
						state_d       = S_FRD;
					end
				end else if (stat.no_room) begin
					cmd.set_code = 1'b1;
					cmd.code     = RC_NOSPACE;
					state_d      = S_RES;
				end else begin
					cmd.alloc_init = 1'b1;
					state_d        = S_GRP;
				end
			end
			S_GRP: begin
				cmd.grp_init = 1'b1;
				state_d      = S_GTEST;
			end
			S_GTEST: begin
				if (!stat.full) begin
					state_d = S_SCAN;
				end else if (stat.last_try) begin
					cmd.set_code = 1'b1;
					cmd.code     = RC_NOSPACE;
					state_d      = S_RES;
				end else begin
					cmd.next_grp = 1'b1;
					state_d      = S_GRP;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					state_d = S_AWR;
				end else if (stat.gdone) begin
					if (stat.last_try) begin
						cmd.set_code = 1'b1;
						cmd.code     = RC_NOSPACE;
						state_d      = S_RES;
					end else begin
						cmd.next_grp = 1'b1;
						state_d      = S_GRP;
					end
				end
			end
			S_AWR: begin
				cmd.alloc_wr = 1'b1;
				cmd.set_code = 1'b1;
				cmd.code     = RC_ALLOC;
				state_d      = S_RES;
			end
			S_FRD: begin
				state_d = S_FWAIT;
			end
			S_FWAIT: begin
				cmd.set_code = 1'b1;
				if (stat.bit_clear) begin
					cmd.code = RC_DOUBLE;
				end else begin
					cmd.free_wr = 1'b1;
					cmd.code    = RC_FREED;
				end
				state_d = S_RES;
			end
			S_RES: begin
				if (!stat.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> hdl/gbba_dp.sv
// ----------------------------------------------------------------------------
// gbba_dp
// Datapath of the allocator: config registers, used-bit map memory, group
// and total counters, divider, scan pipeline and result register.
// BITS_PER_GROUP is a multiple of 64 so a map word never spans two groups.
// ----------------------------------------------------------------------------
module gbba_dp #(
	parameter int MAX_GROUPS     = gbba_pkg::MAX_GROUPS_DEF,
	parameter int BITS_PER_GROUP = gbba_pkg::BITS_PER_GROUP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gbba_pkg::IDX_W-1:0]    cfg_index,
	input  logic [gbba_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_kind,
	input  logic [gbba_pkg::HINT_W-1:0]   in_hint,
	input  logic [gbba_pkg::BLK_W-1:0]    in_block,
	input  gbba_pkg::cmd_t                cmd,
	output gbba_pkg::stat_t               stat,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [gbba_pkg::BLK_W-1:0]    out_block,
	output logic [gbba_pkg::CODE_W-1:0]   out_code,
	output logic [gbba_pkg::BLK_W-1:0]    out_used
);
	import gbba_pkg::*;

	localparam int WPG       = BITS_PER_GROUP / 64;
	localparam int MAP_WORDS = MAX_GROUPS * WPG;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int GW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int NGW       = $clog2(MAX_GROUPS + 1);
	localparam int BPGW      = $clog2(BITS_PER_GROUP + 1);
	localparam int WW        = $clog2(WPG) + 1;

	// config
	logic [GIN_W-1:0] gin_q;
	logic [BPG_W-1:0] bpg_q;
	logic [BLK_W-1:0] tot_q;
	logic             fdb_q;

	// item
	logic              kind_q;
	logic [HINT_W-1:0] hint_q;
	logic [BLK_W-1:0]  nr_q;

	// walk and scan
	logic [GW-1:0]   g_q;
	logic [NGW-1:0]  a_q;
	logic [BPGW-1:0] bits_q;
	logic            full_q;
	logic [BLK_W-1:0] prod_q;
	logic [AW-1:0]   base_q;
	logic [WW-1:0]   rd_w_q;
	logic [WW-1:0]   chk_w_q;
	logic            chk_v_q;
	logic [AW-1:0]   f_addr_q;
	logic [63:0]     f_word_q;
	logic [5:0]      f_pos_q;
	logic [AW-1:0]   fa_q;
	logic [BLK_W-1:0] blk_q;
	logic [AW-1:0]   clr_q;
	logic [CODE_W-1:0] code_q;

	// counters
	logic [CNT_W-1:0] cnt_q [MAX_GROUPS];
	logic [BLK_W-1:0] tu_q;

	// map memory
	logic [63:0]   mem_q [MAP_WORDS];
	logic [63:0]   dout_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0]   wr_data;

	// result
	logic              ov_q;
	logic [BLK_W-1:0]  ob_q;
	logic [CODE_W-1:0] oc_q;
	logic [BLK_W-1:0]  ou_q;

	// effective config
	logic [NGW-1:0]  ng;
	logic [BPGW-1:0] bpg_eff;
	logic [31:0]     gin32, bpg32;

	// divider
	logic [BLK_W-1:0] div_a;
	logic             div_busy;
	logic [BLK_W-1:0] quo;
	logic [BPGW-1:0]  rmd;

	// group and word decode
	logic            is_last;
	logic [BPGW-1:0] grp_bits;
	logic [31:0]     lw;
	logic [5:0]      last_bits;
	logic [63:0]     vmask, freeb;
	logic [5:0]      pos;
	logic [CNT_W-1:0] cnt_g;

	// clamp register values
	assign gin32 = 32'(gin_q);
	assign bpg32 = 32'(bpg_q);
	always_comb begin
		if (gin_q == '0)             ng = NGW'(1);
		else if (gin32 > MAX_GROUPS) ng = NGW'(MAX_GROUPS);
		else                         ng = NGW'(gin32);
		if (bpg32 < 32'd8)                bpg_eff = BPGW'(8);
		else if (bpg32 > BITS_PER_GROUP)  bpg_eff = BPGW'(BITS_PER_GROUP);
		else                              bpg_eff = BPGW'(bpg32);
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gin_q <= GIN_RST;
			bpg_q <= BPG_RST;
			tot_q <= TOTAL_RST;
			fdb_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GROUPS:     gin_q <= cfg_data[GIN_W-1:0];
				CFG_BPG:        bpg_q <= cfg_data[BPG_W-1:0];
				CFG_TOTAL:      tot_q <= cfg_data;
				CFG_FIRST_DATA: fdb_q <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// remainder of total_blocks for allocation, block split for free
	assign div_a = (kind_q != KIND_ALLOC) ? nr_q - BLK_W'(fdb_q) : tot_q;

	gbba_div #(.DW(BLK_W), .VW(BPGW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_a),
		.divisor  (bpg_eff),
		.busy     (div_busy),
		.quo      (quo),
		.rmd      (rmd)
	);

	// group size and word limits
	assign cnt_g     = cnt_q[g_q];
	assign is_last   = 32'(g_q) == 32'(ng) - 32'd1;
	assign grp_bits  = (is_last && rmd != '0) ? rmd : bpg_eff;
	assign lw        = 32'(bits_q - BPGW'(1)) >> 6;
	assign last_bits = 6'(bits_q - BPGW'(1));

	// usable bits of the word under check, lowest clear one
	always_comb begin
		pos = '0;
		for (int b = 0; b < 64; b++)
			vmask[b] = (32'(chk_w_q) < lw) || (6'(b) <= last_bits);
		freeb = ~dout_q & vmask;
		for (int b = 63; b >= 0; b--)
			if (freeb[b]) pos = 6'(b);
	end

	// item, walk and scan registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q <= in_kind;
			hint_q <= in_hint;
			nr_q   <= in_block;
		end
		if (cmd.alloc_init) begin
			g_q <= (32'(hint_q) >= 32'(ng)) ? '0 : GW'(hint_q);
			a_q <= '0;
		end
		if (cmd.next_grp) begin
			a_q <= a_q + 1'b1;
			g_q <= (32'(g_q) + 32'd1 >= 32'(ng)) ? '0 : g_q + 1'b1;
		end
		if (cmd.grp_init) begin
			bits_q  <= grp_bits;
			full_q  <= 32'(cnt_g) >= 32'(grp_bits);
			prod_q  <= BLK_W'(32'(g_q) * 32'(bpg_eff));
			base_q  <= AW'(32'(g_q) * WPG);
			rd_w_q  <= '0;
			chk_v_q <= 1'b0;
		end
		if (cmd.scan) begin
			rd_w_q  <= rd_w_q + 1'b1;
			chk_w_q <= rd_w_q;
			chk_v_q <= 32'(rd_w_q) <= lw;
			if (stat.hit) begin
				f_addr_q <= base_q + AW'(chk_w_q);
				f_word_q <= dout_q;
				f_pos_q  <= pos;
				blk_q    <= BLK_W'(32'(prod_q) + 32'(chk_w_q) * 32'd64 + 32'(pos)
					+ 32'(fdb_q));
			end
		end
		if (cmd.free_init) begin
			g_q     <= GW'(quo);
			fa_q    <= AW'(32'(GW'(quo)) * WPG + (32'(rmd) >> 6));
			f_pos_q <= rmd[5:0];
		end
		if (cmd.set_code) code_q <= cmd.code;
	end

	// map memory ports
	assign rd_addr = cmd.scan ? base_q + AW'(rd_w_q) : fa_q;
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.alloc_wr) begin
			wr_en   = 1'b1;
			wr_addr = f_addr_q;
			wr_data = f_word_q | (64'd1 << f_pos_q);
		end else if (cmd.free_wr) begin
			wr_en   = 1'b1;
			wr_addr = fa_q;
			wr_data = dout_q & ~(64'd1 << f_pos_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		dout_q <= mem_q[rd_addr];
	end

	// clearing pass pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           clr_q <= '0;
		else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
	end

	// used counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tu_q <= '0;
			for (int i = 0; i < MAX_GROUPS; i++) cnt_q[i] <= '0;
		end else if (cmd.alloc_wr) begin
			tu_q       <= tu_q + 1'b1;
			cnt_q[g_q] <= cnt_g + 1'b1;
		end else if (cmd.free_wr) begin
			if (tu_q != '0)  tu_q <= tu_q - 1'b1;
			if (cnt_g != '0) cnt_q[g_q] <= cnt_g - 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           ov_q <= 1'b0;
		else if (cmd.res_load) ov_q <= 1'b1;
		else if (out_ready)    ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			ob_q <= (code_q == RC_ALLOC) ? blk_q : '0;
			oc_q <= code_q;
			ou_q <= tu_q;
		end
	end

	// status to the controller
	always_comb begin
		stat.clr_done  = clr_q == AW'(MAP_WORDS - 1);
		stat.kind      = kind_q;
		stat.div_busy  = div_busy;
		stat.no_room   = tu_q >= tot_q;
		stat.free_bad  = nr_q == '0 || nr_q >= tot_q || 32'(quo) >= 32'(ng);
		stat.full      = full_q;
		stat.last_try  = 32'(a_q) == 32'(ng) - 32'd1;
		stat.hit       = chk_v_q && (freeb != '0);
		stat.gdone     = chk_v_q && (freeb == '0) && (32'(chk_w_q) == lw);
		stat.bit_clear = !dout_q[f_pos_q];
		stat.out_busy  = ov_q && !out_ready;
	end

	assign out_valid = ov_q;
	assign out_block = ob_q;
	assign out_code  = oc_q;
	assign out_used  = ou_q;

endmodule

>>> hdl/grouped_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator
// Block allocator over a grouped used-bit map with group and total counters.
//
// Input beats (s_*) carry one request: allocate (tuser 0) with a group hint,
// or free (tuser 1) of a block number. Each request gives one result beat
// (m_*) with the allocated number, a status code and the used total.
// Config writes (cfg_we, cfg_index, cfg_data) are taken in any cycle and
// must only happen while no request is in flight.
// After reset the map memory is cleared one word a cycle, all MAX_GROUPS *
// BITS_PER_GROUP / 64 words (2048 at the defaults); s_tready stays low.
// One request is worked at a time. A free in range goes from intake through
// a divide by blocks_per_group, a decision, a map read and a map write to
// its result beat. An allocate takes the same divide and decision, then a
// group test per full group skipped and, per scanned group, a group set-up
// and a scan that reads one 64-bit map word a cycle.
// The result sits in an output register; a new request is taken while it
// waits. If m_tready stays low, the next result waits until it drains.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator #(
	parameter int MAX_GROUPS     = gbba_pkg::MAX_GROUPS_DEF,
	parameter int BITS_PER_GROUP = gbba_pkg::BITS_PER_GROUP_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [gbba_pkg::IDX_W-1:0] cfg_index,
	input  logic [gbba_pkg::CFG_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [23:0]                s_tdata,  // pref_group, block_number, pad
	input  logic [0:0]                 s_tuser,  // kind
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [39:0]                m_tdata,  // allocated_block, used_total, pad
	output logic [2:0]                 m_tuser   // status
);
	import gbba_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic [BLK_W-1:0]  out_block, out_used;
	logic [CODE_W-1:0] out_code;

	gbba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbba_dp #(
		.MAX_GROUPS     (MAX_GROUPS),
		.BITS_PER_GROUP (BITS_PER_GROUP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_kind   (s_tuser[0]),
		.in_hint   (s_tdata[3:0]),
		.in_block  (s_tdata[21:4]),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_block (out_block),
		.out_code  (out_code),
		.out_used  (out_used)
	);

	// result beat packing
	assign m_tdata = {4'b0, out_used, out_block};
	assign m_tuser = out_code;

endmodule

>>> hdl/gbba_chk.sv
// ----------------------------------------------------------------------------
// gbba_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module gbba_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import gbba_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed under stall");

	// status is a defined code
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == RC_ALLOC || m_tuser == RC_FREED ||
			m_tuser == RC_NOSPACE || m_tuser == RC_RANGE || m_tuser == RC_DOUBLE))
		else $error("undefined status");

	// number is zero unless a block was allocated
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != RC_ALLOC |-> m_tdata[17:0] == 18'd0)
		else $error("nonzero number without allocation");

	// one request at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken back to back");

endmodule

bind grouped_bitmap_block_allocator gbba_chk u_gbba_chk (.*);

>>> verif/grouped_bitmap_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator_tb
// Self-checking bench for the grouped bitmap block allocator. Requests go in
// as stream beats, results are checked in order against a behavioral model
// of the used map and counters, over several config settings and idle mixes.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator_tb;
	import gbba_pkg::*;

	localparam int NGRP  = MAX_GROUPS_DEF;
	localparam int NBITS = BITS_PER_GROUP_DEF;
	localparam logic KIND_FREE = 1'b1;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [BLK_W-1:0]  blk;
		logic [CODE_W-1:0] code;
		logic [BLK_W-1:0]  used;
	} alloc_res_t;

	// behavioral model of the allocator plus the queue of pending results
	class alloc_scoreboard;
		bit map [NGRP*NBITS];
		int grp_cnt [NGRP];
		int used_cnt;
		int groups_cfg, bpg_cfg, total_cfg, fdb_cfg;
		alloc_res_t pending [$];
		int errors;

		function void clear_state();
			foreach (map[i]) map[i] = 0;
			foreach (grp_cnt[i]) grp_cnt[i] = 0;
			used_cnt = 0;
			groups_cfg = 16; bpg_cfg = 8192; total_cfg = 131072; fdb_cfg = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, int val);
			case (idx)
				CFG_GROUPS:     groups_cfg = val & 'h1f;
				CFG_BPG:        bpg_cfg = val & 'h3fff;
				CFG_TOTAL:      total_cfg = val & 'h3ffff;
				CFG_FIRST_DATA: fdb_cfg = val & 1;
				default:        ;
			endcase
		endfunction

		function int ngroups();
			if (groups_cfg == 0) return 1;
			if (groups_cfg > NGRP) return NGRP;
			return groups_cfg;
		endfunction

		function int gsize();
			if (bpg_cfg < 8) return 8;
			if (bpg_cfg > NBITS) return NBITS;
			return bpg_cfg;
		endfunction

		// work out the result of one accepted request
		function void note_request(logic kind, int hint, int nr);
			alloc_res_t r;
			int ng, bpg, g, bits, adj;
			bit done;
			ng = ngroups(); bpg = gsize();
			r.blk = '0;
			done = 0;
			if (kind == KIND_ALLOC) begin
				r.code = RC_NOSPACE;
				if (hint >= ng) hint = 0;
				if (used_cnt < total_cfg) begin
					for (int a = 0; a < ng && !done; a++) begin
						g = (hint + a) % ng;
						bits = bpg;
						if (g == ng - 1 && (total_cfg % bpg) != 0) bits = total_cfg % bpg;
						if (grp_cnt[g] >= bits) continue;
						for (int b = 0; b < bits && !done; b++) begin
							if (!map[g*NBITS+b]) begin
								map[g*NBITS+b] = 1;
								grp_cnt[g] = (grp_cnt[g] + 1) & 'h3fff;
								used_cnt = (used_cnt + 1) & 'h3ffff;
								r.code = RC_ALLOC;
								r.blk = BLK_W'(g*bpg + b + fdb_cfg);
								done = 1;
							end
						end
					end
				end
			end else if (nr == 0 || nr >= total_cfg) begin
				r.code = RC_RANGE;
			end else begin
				adj = nr - fdb_cfg;
				g = adj / bpg;
				if (g >= ng) r.code = RC_RANGE;
				else if (!map[g*NBITS + adj % bpg]) r.code = RC_DOUBLE;
				else begin
					map[g*NBITS + adj % bpg] = 0;
					if (grp_cnt[g] > 0) grp_cnt[g]--;
					if (used_cnt > 0) used_cnt--;
					r.code = RC_FREED;
				end
			end
			r.used = BLK_W'(used_cnt);
			pending.push_back(r);
		endfunction

		function void check_result(logic [BLK_W-1:0] blk, logic [CODE_W-1:0] code,
				logic [BLK_W-1:0] used);
			alloc_res_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (blk !== e.blk) begin
				$error("allocated_block expected %0d got %0d", e.blk, blk); errors++;
			end
			if (code !== e.code) begin
				$error("status expected %0d got %0d", e.code, code); errors++;
			end
			if (used !== e.used) begin
				$error("used_total expected %0d got %0d", e.used, used); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 0, s_tready;
	logic [23:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid, m_tready = 0;
	logic [39:0] m_tdata;
	logic [2:0] m_tuser;

	alloc_scoreboard sb;
	int send_idle_pct, recv_stall_pct;
	longint cycles;
	int n_alloc, n_free;
	bit timed_out;

	grouped_bitmap_block_allocator DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver: random stall and result check
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[17:0], m_tuser, m_tdata[35:18]);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			timed_out = 1;
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_cfg(logic [IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= CFG_W'(val);
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// valid stays up after the accepting edge until the next beat or an idle
	task automatic send_beat(logic kind, int hint, int nr);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {2'b0, 18'(nr), 4'(hint)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(kind, hint, nr);
		if (kind == KIND_ALLOC) n_alloc++; else n_free++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_geometry(int groups, int bpg, int total, int fdb);
		drain();
		write_cfg(CFG_GROUPS, groups);
		write_cfg(CFG_BPG, bpg);
		write_cfg(CFG_TOTAL, total);
		write_cfg(CFG_FIRST_DATA, fdb);
	endtask

	// half allocs, frees mostly of numbers up to the total plus two, some noise
	task automatic random_run(int count);
		int nr, k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 50) send_beat(KIND_ALLOC, $urandom_range(15), $urandom_range(18'h3ffff));
			else begin
				if (k < 90) nr = $urandom_range(sb.total_cfg + 2);
				else nr = $urandom_range(18'h3ffff);
				send_beat(KIND_FREE, $urandom_range(15), nr);
			end
		end
	endtask

	initial begin
		sb = new();
		sb.clear_state();
		send_idle_pct = 0; recv_stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: default geometry, extremes of the fields
		send_beat(KIND_ALLOC, 15, 0);
		send_beat(KIND_ALLOC, 15, 18'h3ffff);
		send_beat(KIND_ALLOC, 0, 0);
		send_beat(KIND_FREE, 0, 0);
		send_beat(KIND_FREE, 15, 18'h3ffff);
		send_beat(KIND_FREE, 0, 131072);
		send_beat(KIND_FREE, 0, 8192);
		send_beat(KIND_FREE, 0, 8192);
		send_beat(KIND_FREE, 0, 1);
		// tiny geometry with short last group, out-of-use hint, no space
		set_geometry(2, 8, 13, 1);
		for (int i = 0; i < 15; i++) send_beat(KIND_ALLOC, (i < 4) ? 15 : 1, 0);
		send_beat(KIND_FREE, 0, 12);
		send_beat(KIND_FREE, 0, 5);
		send_beat(KIND_ALLOC, 1, 0);
		// out-of-range register values get clamped
		set_geometry(0, 3, 20, 0);
		for (int i = 0; i < 10; i++) send_beat(KIND_ALLOC, i, 0);
		set_geometry(31, 16383, 40, 1);
		for (int i = 0; i < 4; i++) send_beat(KIND_ALLOC, 0, 0);

		// random phases over several settings and idle mixes
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				3: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			case (p)
				0: set_geometry(4, 8, 30, 0);
				1: set_geometry(16, 64, 1000, 1);
				2: set_geometry(3, 100, 250, 0);
				3: set_geometry(1, 8, 1, 0);
				4: set_geometry(16, 8, 128, 1);
				5: set_geometry(5, 128, 600, 0);
				6: set_geometry(2, 200, 300, 1);
				7: set_geometry(16, 16, 200, 0);
			endcase
			random_run(160);
			if (p == 3) drain();
		end
		drain();
		$display("covered %0d allocate and %0d free requests over 12 geometries", n_alloc,
			n_free);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
